@@ hw/rtl/jkfe_pkg.sv @@
// Package for the key field extractor: capture modes, controller states,
// command and status structs, key byte tables and character constants.
// No dependencies.
package jkfe_pkg;

    typedef enum logic [1:0] {
        CAP_IDLE = 2'd0,
        CAP_MAC  = 2'd1,
        CAP_NAME = 2'd2
    } t_cap_mode;

    typedef enum logic {
        ST_TAKE = 1'b0,
        ST_PAD  = 1'b1
    } t_state;

    typedef struct packed {
        logic accept;
        logic pad_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic out_free;
        logic pad_more;
        logic pad_last;
    } t_dp_stat;

    localparam logic [7:0] CHR_LBRACE = 8'h7B;
    localparam logic [7:0] CHR_QUOTE  = 8'h22;
    localparam logic [7:0] CHR_SPACE  = 8'h20;

    localparam logic [2:0] MAC_KEY_LEN   = 3'd6;
    localparam logic [2:0] MAC_KEY_LAST  = 3'd5;
    localparam logic [2:0] NAME_KEY_LEN  = 3'd7;
    localparam logic [2:0] NAME_KEY_LAST = 3'd6;

    // mac":"
    function automatic logic [7:0] f_mac_key(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h6D;
            3'd1:    ch = 8'h61;
            3'd2:    ch = 8'h63;
            3'd3:    ch = 8'h22;
            3'd4:    ch = 8'h3A;
            3'd5:    ch = 8'h22;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // nome":"
    function automatic logic [7:0] f_name_key(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h6E;
            3'd1:    ch = 8'h6F;
            3'd2:    ch = 8'h6D;
            3'd3:    ch = 8'h65;
            3'd4:    ch = 8'h22;
            3'd5:    ch = 8'h3A;
            3'd6:    ch = 8'h22;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ hw/rtl/jkfe_ctrl.sv @@
// Controller of the key field extractor: takes bytes or runs a padding burst.
// Depends on jkfe_pkg.
module jkfe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  jkfe_pkg::t_dp_stat i_stat,
    output jkfe_pkg::t_ctl_cmd o_cmd
);
    import jkfe_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_TAKE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_ready         = 1'b0;
        o_cmd.accept    = 1'b0;
        o_cmd.pad_load  = 1'b0;
        unique case (r_state)
            ST_TAKE: begin
                o_ready      = i_stat.out_free;
                o_cmd.accept = i_valid && i_stat.out_free;
                if (o_cmd.accept && i_stat.pad_more) begin
                    n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                // one padding space per free output slot
                o_cmd.pad_load = i_stat.out_free;
                if (i_stat.out_free && i_stat.pad_last) begin
                    n_state = ST_TAKE;
                end
            end
            default: n_state = ST_TAKE;
        endcase
    end

endmodule

@@ hw/rtl/jkfe_dpath.sv @@
// Datapath of the key field extractor: key matchers, capture state, record
// counter and the output register. Depends on jkfe_pkg.
module jkfe_dpath #(
    parameter int RECORD_SLOTS = 16,
    parameter int MAC_CHARS    = 12,
    parameter int NAME_CHARS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jkfe_pkg::t_ctl_cmd i_cmd,
    output jkfe_pkg::t_dp_stat o_stat,
    input  logic [7:0]         i_data_byte,
    input  logic               i_response_start,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [3:0]         o_record_index,
    output logic               o_field_kind,
    output logic [3:0]         o_char_position,
    output logic [7:0]         o_char_value,
    output logic [4:0]         o_records_seen,
    output logic               o_slot_overflow,
    output logic               o_last_write
);
    import jkfe_pkg::*;

    localparam int              CNT_W     = $clog2(RECORD_SLOTS + 1);
    localparam logic [3:0]      MAC_LAST  = 4'(MAC_CHARS - 1);
    localparam logic [3:0]      NAME_LAST = 4'(NAME_CHARS - 1);
    localparam logic [CNT_W-1:0] SLOT_MAX = CNT_W'(RECORD_SLOTS);

    t_cap_mode        r_mode, n_mode;
    logic [3:0]       r_pos, n_pos;
    logic [2:0]       r_mac_kp, n_mac_kp;
    logic [2:0]       r_name_kp, n_name_kp;
    logic [CNT_W-1:0] r_record_count, n_record_count;
    logic             r_overflow, n_overflow;
    logic [3:0]       r_pad_pos, n_pad_pos;

    logic             r_out_valid, n_out_valid;
    logic [3:0]       r_out_index;
    logic             r_out_kind;
    logic [3:0]       r_out_pos;
    logic [7:0]       r_out_char;
    logic [4:0]       r_out_seen;
    logic             r_out_ovf;
    logic             r_out_last;

    t_cap_mode        w_eff_mode;
    logic [3:0]       w_eff_pos;
    logic [2:0]       w_eff_mac_kp;
    logic [2:0]       w_eff_name_kp;
    logic [2:0]       w_np;
    logic [2:0]       w_mp;
    logic             w_open;
    logic             w_name_term;
    logic             w_emit;
    logic             w_kind;
    logic [3:0]       w_pos;
    logic [7:0]       w_char;
    logic             w_last;
    logic             w_pad_more;
    logic [31:0]      w_cnt32;
    logic [31:0]      w_idx32;

    assign w_cnt32 = 32'(r_record_count);
    assign w_idx32 = w_cnt32 - 32'd1;

    always_comb begin
        // a response start clears matchers and capture before the byte
        w_eff_mode    = i_response_start ? CAP_IDLE : r_mode;
        w_eff_pos     = i_response_start ? 4'd0 : r_pos;
        w_eff_mac_kp  = i_response_start ? 3'd0 : r_mac_kp;
        w_eff_name_kp = i_response_start ? 3'd0 : r_name_kp;
        w_np          = (w_eff_name_kp < NAME_KEY_LEN) ? w_eff_name_kp : 3'd0;
        w_mp          = (w_eff_mac_kp < MAC_KEY_LEN) ? w_eff_mac_kp : 3'd0;
        w_open        = r_record_count != '0;
        w_name_term   = (i_data_byte == CHR_QUOTE) || (w_eff_pos >= NAME_LAST);

        n_mode         = r_mode;
        n_pos          = r_pos;
        n_mac_kp       = r_mac_kp;
        n_name_kp      = r_name_kp;
        n_record_count = r_record_count;
        n_overflow     = r_overflow;
        n_pad_pos      = r_pad_pos;
        w_emit         = 1'b0;
        w_kind         = 1'b0;
        w_pos          = w_eff_pos;
        w_char         = i_data_byte;
        w_last         = 1'b1;
        w_pad_more     = 1'b0;

        if (i_cmd.accept) begin
            n_mode    = w_eff_mode;
            n_pos     = w_eff_pos;
            n_mac_kp  = w_eff_mac_kp;
            n_name_kp = w_eff_name_kp;
            case (w_eff_mode)
                CAP_MAC: begin
                    w_emit = w_open;
                    w_kind = 1'b0;
                    if (w_eff_pos < MAC_LAST) begin
                        n_pos = w_eff_pos + 4'd1;
                    end else begin
                        n_mode = CAP_IDLE;
                        n_pos  = 4'd0;
                    end
                end
                CAP_NAME: begin
                    w_emit = w_open;
                    w_kind = 1'b1;
                    if (!w_name_term) begin
                        n_pos = w_eff_pos + 4'd1;
                    end else begin
                        // drop the byte, pad from here to the end of the name
                        w_char     = CHR_SPACE;
                        w_last     = w_eff_pos >= NAME_LAST;
                        w_pad_more = w_open && !w_last;
                        n_pad_pos  = w_eff_pos + 4'd1;
                        n_mode     = CAP_IDLE;
                        n_pos      = 4'd0;
                    end
                end
                default: begin
                    if (i_data_byte == CHR_LBRACE) begin
                        if (r_record_count < SLOT_MAX) begin
                            n_record_count = r_record_count + CNT_W'(1);
                        end else begin
                            n_overflow = 1'b1;
                        end
                    end else if (i_data_byte == f_name_key(w_np)) begin
                        if (w_np < NAME_KEY_LAST) begin
                            n_name_kp = w_np + 3'd1;
                        end else begin
                            n_name_kp = 3'd0;
                            n_mode    = CAP_NAME;
                            n_pos     = 4'd0;
                        end
                    end else if (i_data_byte == f_mac_key(w_mp)) begin
                        if (w_mp < MAC_KEY_LAST) begin
                            n_mac_kp = w_mp + 3'd1;
                        end else begin
                            n_mac_kp = 3'd0;
                            n_mode   = CAP_MAC;
                            n_pos    = 4'd0;
                        end
                    end else begin
                        n_mac_kp  = 3'd0;
                        n_name_kp = 3'd0;
                    end
                end
            endcase
        end else if (i_cmd.pad_load) begin
            w_emit    = 1'b1;
            w_kind    = 1'b1;
            w_pos     = r_pad_pos;
            w_char    = CHR_SPACE;
            w_last    = r_pad_pos >= NAME_LAST;
            n_pad_pos = r_pad_pos + 4'd1;
        end

        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= CAP_IDLE;
            r_pos          <= 4'd0;
            r_mac_kp       <= 3'd0;
            r_name_kp      <= 3'd0;
            r_record_count <= '0;
            r_overflow     <= 1'b0;
            r_pad_pos      <= 4'd0;
            r_out_valid    <= 1'b0;
        end else begin
            r_mode         <= n_mode;
            r_pos          <= n_pos;
            r_mac_kp       <= n_mac_kp;
            r_name_kp      <= n_name_kp;
            r_record_count <= n_record_count;
            r_overflow     <= n_overflow;
            r_pad_pos      <= n_pad_pos;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_index <= w_idx32[3:0];
            r_out_kind  <= w_kind;
            r_out_pos   <= w_pos;
            r_out_char  <= w_char;
            r_out_seen  <= w_cnt32[4:0];
            r_out_ovf   <= r_overflow;
            r_out_last  <= w_last;
        end
    end

    assign o_stat.out_free  = !r_out_valid || i_ready;
    assign o_stat.pad_more  = w_pad_more;
    assign o_stat.pad_last  = r_pad_pos >= NAME_LAST;

    assign o_valid         = r_out_valid;
    assign o_record_index  = r_out_index;
    assign o_field_kind    = r_out_kind;
    assign o_char_position = r_out_pos;
    assign o_char_value    = r_out_char;
    assign o_records_seen  = r_out_seen;
    assign o_slot_overflow = r_out_ovf;
    assign o_last_write    = r_out_last;

endmodule

@@ hw/rtl/json_key_field_extractor_unit.sv @@
// Top level of the key field extractor: controller plus datapath.
// Depends on jkfe_pkg, jkfe_ctrl and jkfe_dpath.
//
// Takes one response byte per cycle unless stalled, and emits one character
// write per result. A byte is taken whenever the output register is free
// or being drained; each byte causes at most one write, except a name
// terminator, which pads the rest of the name with spaces at one write per
// cycle while the receiver takes them: a terminator before the last position
// holds the input while the single output register drains the burst.
// '{' opens a record slot; the count saturates at RECORD_SLOTS and then sets
// the sticky overflow flag. Writes before the first record are dropped.
module json_key_field_extractor_unit #(
    parameter int RECORD_SLOTS = 16,
    parameter int MAC_CHARS    = 12,
    parameter int NAME_CHARS   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_response_start,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_record_index,
    output logic       o_field_kind,
    output logic [3:0] o_char_position,
    output logic [7:0] o_char_value,
    output logic [4:0] o_records_seen,
    output logic       o_slot_overflow,
    output logic       o_last_write
);
    import jkfe_pkg::*;

    t_ctl_cmd w_cmd;
    t_dp_stat w_stat;

    jkfe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    jkfe_dpath #(
        .RECORD_SLOTS (RECORD_SLOTS),
        .MAC_CHARS    (MAC_CHARS),
        .NAME_CHARS   (NAME_CHARS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_data_byte      (i_data_byte),
        .i_response_start (i_response_start),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_record_index   (o_record_index),
        .o_field_kind     (o_field_kind),
        .o_char_position  (o_char_position),
        .o_char_value     (o_char_value),
        .o_records_seen   (o_records_seen),
        .o_slot_overflow  (o_slot_overflow),
        .o_last_write     (o_last_write)
    );

`ifndef ASSERT_OFF
    // mac characters are written one per byte
    a_mac_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_field_kind |-> o_last_write)
        else $error("mac write not marked last");

    // input stays blocked while a padding burst is pending
    a_burst_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_write |-> !o_ready)
        else $error("byte taken during padding burst");

    // a taken non-final pad is followed at once by the next position
    a_pad_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_write |=>
            o_valid && o_field_kind && (o_char_value == CHR_SPACE) &&
            (o_char_position == 4'($past(o_char_position) + 4'd1)))
        else $error("padding burst broken");

    // record count never passes the slot count
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_records_seen) <= RECORD_SLOTS) || (RECORD_SLOTS > 31))
        else $error("record count above slot count");
`endif

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for json_key_field_extractor_unit: byte stream in, character writes out.
// Predicts every write in the bench itself; depends on jkfe_pkg and the unit's RTL.
// Sender idles in bursts, receiver stalls on its own pattern; a watchdog bounds the run.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jkfe_pkg::*;

    localparam int RECORD_SLOTS = 16;
    localparam int MAC_CHARS    = 12;
    localparam int NAME_CHARS   = 16;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 10;

    localparam logic KIND_MAC  = 1'b0;
    localparam logic KIND_NAME = 1'b1;

    localparam logic [47:0] MAC_KEY_TEXT  = "mac\":\"";
    localparam logic [55:0] NAME_KEY_TEXT = "nome\":\"";

    typedef struct packed {
        logic [3:0] rec_idx;
        logic       kind;
        logic [3:0] pos;
        logic [7:0] chr;
        logic [4:0] seen;
        logic       ovf;
        logic       last;
    } t_char_write;

    logic       i_clk;
    logic       i_rst_n          = 1'b0;
    logic       i_valid          = 1'b0;
    logic [7:0] i_data_byte      = 8'h00;
    logic       i_response_start = 1'b0;
    logic       i_ready          = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [3:0] o_record_index;
    logic       o_field_kind;
    logic [3:0] o_char_position;
    logic [7:0] o_char_value;
    logic [4:0] o_records_seen;
    logic       o_slot_overflow;
    logic       o_last_write;

    // extractor state as the bench sees it
    logic [2:0] mac_pos;
    logic [2:0] name_pos;
    t_cap_mode  cap_mode;
    logic [3:0] cap_pos;
    logic [4:0] rec_count;
    logic       slot_ovf;

    t_char_write char_writes_due[$];

    int mismatches  = 0;
    int bytes_sent  = 0;
    int burst_left  = 0;
    int quiet_count = 0;
    int rx_cycle    = 0;
    int stall_left  = 0;

    json_key_field_extractor_unit #(
        .RECORD_SLOTS(RECORD_SLOTS),
        .MAC_CHARS   (MAC_CHARS),
        .NAME_CHARS  (NAME_CHARS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_response_start(i_response_start),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_record_index  (o_record_index),
        .o_field_kind    (o_field_kind),
        .o_char_position (o_char_position),
        .o_char_value    (o_char_value),
        .o_records_seen  (o_records_seen),
        .o_slot_overflow (o_slot_overflow),
        .o_last_write    (o_last_write)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void queue_write(input logic kind, input logic [3:0] pos,
                                        input logic [7:0] chr, input logic last);
        t_char_write w;
        w.rec_idx = rec_count[3:0] - 4'd1;
        w.kind    = kind;
        w.pos     = pos;
        w.chr     = chr;
        w.seen    = rec_count;
        w.ovf     = slot_ovf;
        w.last    = last;
        char_writes_due.push_back(w);
    endfunction

    task automatic extract_fields(input logic [7:0] b, input logic st);
        logic [7:0] name_chr;
        logic [7:0] mac_chr;
        int         j;
        if (st) begin
            mac_pos  = 3'd0;
            name_pos = 3'd0;
            cap_mode = CAP_IDLE;
            cap_pos  = 4'd0;
        end
        case (cap_mode)
            CAP_MAC: begin
                if (rec_count != 0)
                    queue_write(KIND_MAC, cap_pos, b, 1'b1);
                if (cap_pos < MAC_CHARS - 1) begin
                    cap_pos = cap_pos + 4'd1;
                end else begin
                    cap_mode = CAP_IDLE;
                    cap_pos  = 4'd0;
                end
            end
            CAP_NAME: begin
                if (b != CHR_QUOTE && cap_pos < NAME_CHARS - 1) begin
                    if (rec_count != 0)
                        queue_write(KIND_NAME, cap_pos, b, 1'b1);
                    cap_pos = cap_pos + 4'd1;
                end else begin
                    // terminator is dropped; pad the rest of the name with spaces
                    for (j = int'(cap_pos); j < NAME_CHARS; j++) begin
                        if (rec_count != 0)
                            queue_write(KIND_NAME, j[3:0], CHR_SPACE, j == NAME_CHARS - 1);
                    end
                    cap_mode = CAP_IDLE;
                    cap_pos  = 4'd0;
                end
            end
            default: begin
                name_chr = NAME_KEY_TEXT[55 - 8 * int'(name_pos) -: 8];
                mac_chr  = MAC_KEY_TEXT[47 - 8 * int'(mac_pos) -: 8];
                // brace first, then the name key, then the mac key
                if (b == CHR_LBRACE) begin
                    if (rec_count < RECORD_SLOTS)
                        rec_count = rec_count + 5'd1;
                    else
                        slot_ovf = 1'b1;
                end else if (b == name_chr) begin
                    if (name_pos != NAME_KEY_LAST) begin
                        name_pos = name_pos + 3'd1;
                    end else begin
                        name_pos = 3'd0;
                        cap_mode = CAP_NAME;
                        cap_pos  = 4'd0;
                    end
                end else if (b == mac_chr) begin
                    if (mac_pos != MAC_KEY_LAST) begin
                        mac_pos = mac_pos + 3'd1;
                    end else begin
                        mac_pos  = 3'd0;
                        cap_mode = CAP_MAC;
                        cap_pos  = 4'd0;
                    end
                end else begin
                    mac_pos  = 3'd0;
                    name_pos = 3'd0;
                end
            end
        endcase
    endtask

    // Entered and left at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic st);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid          = 1'b1;
        i_data_byte      = b;
        i_response_start = st;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        extract_fields(b, st);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            send_byte(s[k], 1'b0);
    endtask

    task automatic send_mac_field();
        send_text("mac\":\"");
        repeat (MAC_CHARS)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 29) == 0);
    endtask

    task automatic send_name_field();
        int         len;
        logic [7:0] b;
        len = ($urandom_range(0, 3) == 0) ? NAME_CHARS - 1 : $urandom_range(0, NAME_CHARS - 2);
        send_text("nome\":\"");
        repeat (len) begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == CHR_QUOTE);
            send_byte(b, 1'b0);
        end
        if (len < NAME_CHARS - 1)
            send_byte(CHR_QUOTE, 1'b0);
        else
            send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic send_noise();
        string key;
        int    k;
        int    cut;
        if ($urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end else begin
            // broken key: a prefix followed by a stray byte
            if ($urandom_range(0, 1) == 0)
                key = "mac\":\"";
            else
                key = "nome\":\"";
            cut = $urandom_range(1, key.len() - 1);
            for (k = 0; k < cut; k++)
                send_byte(key[k], 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic send_random_record();
        int pick;
        send_byte(CHR_LBRACE, $urandom_range(0, 9) == 0);
        repeat ($urandom_range(1, 3)) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                send_mac_field();
            else if (pick < 8)
                send_name_field();
            else
                send_noise();
        end
    endtask

    // Writes before any record are dropped.
    task automatic test_closed_record();
        int k;
        send_byte(8'h00, 1'b1);
        send_text("mac\":\"");
        for (k = 0; k < MAC_CHARS; k++)
            send_byte(k[0] ? 8'hFF : 8'h00, 1'b0);
        send_text("nome\":\"xy\"");
    endtask

    task automatic test_mac_capture();
        send_byte(CHR_LBRACE, 1'b0);
        send_text("mac\":\"");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CHR_LBRACE, 1'b0);
        send_byte(CHR_QUOTE, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(CHR_SPACE, 1'b0);
        send_byte("z", 1'b0);
    endtask

    task automatic test_name_capture();
        int k;
        send_text("nome\":\"ok\"");
        // empty name: all positions padded
        send_text("nome\":\"\"");
        // full name: the byte at the last position terminates
        send_text("nome\":\"");
        for (k = 0; k < NAME_CHARS - 1; k++)
            send_byte(8'h41 + k[7:0], 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // Name key bytes between mac key bytes advance the name matcher without resetting the mac matcher.
    task automatic test_key_interleave();
        int k;
        send_text("mnomac\":\"");
        for (k = 0; k < MAC_CHARS; k++)
            send_byte(8'h30 + k[7:0], 1'b0);
        send_text("macX");
    endtask

    task automatic test_restart();
        send_text("mac\":\"ab");
        send_byte(CHR_LBRACE, 1'b1);
        send_text("nome\"");
        send_byte(":", 1'b1);
        send_text("\"x");
        send_text("nome\":\"ab");
        send_byte(CHR_QUOTE, 1'b1);
    endtask

    task automatic test_random_records(input int count);
        int first;
        first = bytes_sent;
        while (bytes_sent - first < count)
            send_random_record();
    endtask

    task automatic test_slot_overflow();
        repeat (RECORD_SLOTS + 1)
            send_byte(CHR_LBRACE, 1'b0);
        send_mac_field();
    endtask

    // receiver: free-running windows of no stall, random, long stalls and a fixed pattern
    always @(negedge i_clk) begin
        rx_cycle++;
        case ((rx_cycle / 150) % 4)
            0: i_ready = 1'b1;
            1: i_ready = ($urandom_range(0, 1) == 1);
            2: begin
                if (stall_left != 0) begin
                    i_ready = 1'b0;
                    stall_left--;
                end else begin
                    i_ready = 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(1, 20);
                end
            end
            default: i_ready = (rx_cycle % 5) < 3;
        endcase
    end

    always @(posedge i_clk) begin : check_writes
        t_char_write got;
        t_char_write want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_record_index, o_field_kind, o_char_position, o_char_value,
                   o_records_seen, o_slot_overflow, o_last_write};
            if (char_writes_due.size() == 0) begin
                if (mismatches < REPORT_MAX) begin
                    $write("unexpected write: idx %0d kind %0d pos %0d chr %h ",
                           got.rec_idx, got.kind, got.pos, got.chr);
                    $display("seen %0d ovf %0d last %0d", got.seen, got.ovf, got.last);
                end
                mismatches++;
            end else begin
                want = char_writes_due.pop_front();
                if (got !== want) begin
                    if (mismatches < REPORT_MAX) begin
                        $write("write mismatch: exp idx %0d kind %0d pos %0d chr %h seen %0d ",
                               want.rec_idx, want.kind, want.pos, want.chr, want.seen);
                        $write("ovf %0d last %0d / got idx %0d kind %0d pos %0d chr %h ",
                               want.ovf, want.last, got.rec_idx, got.kind, got.pos,
                               got.chr);
                        $display("seen %0d ovf %0d last %0d", got.seen, got.ovf, got.last);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_count = 0;
        end else begin
            quiet_count++;
            if (quiet_count >= QUIET_LIMIT) begin
                $display("** json_key_field_extractor_unit: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        mac_pos   = 3'd0;
        name_pos  = 3'd0;
        cap_mode  = CAP_IDLE;
        cap_pos   = 4'd0;
        rec_count = 5'd0;
        slot_ovf  = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_closed_record();
        test_mac_capture();
        test_name_capture();
        test_key_interleave();
        test_restart();
        test_random_records(4);
        test_slot_overflow();
        test_random_records(4);

        i_valid = 1'b0;
        while (char_writes_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("** json_key_field_extractor_unit: PASSED **");
        else
            $display("** json_key_field_extractor_unit: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/jkfe_pkg.sv
hw/rtl/jkfe_ctrl.sv
hw/rtl/jkfe_dpath.sv
hw/rtl/json_key_field_extractor_unit.sv
tb/tb_top.sv
